// ===== src/polyproj_pkg.sv =====
// Shared widths, codes, controller/datapath command types and helpers of the projector.
package polyproj_pkg;

   localparam int COORD_W   = 32;
   localparam int TRIG_W    = 16;
   localparam int ZOOM_W    = 15;
   localparam int PIX_W     = 19;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   localparam int DEF_SCREEN_WIDTH  = 1024;
   localparam int DEF_SCREEN_HEIGHT = 768;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_COS_AZ = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_AZ = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_EL = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_EL = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_X  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_Y  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_Z  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM   = 4'd7;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CULLED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OFFSCR  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_START   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SEGMENT = 3'd4;

   // Multiply sequence: eleven steps of the shared multiplier.
   localparam int STEP_W    = 4;
   localparam int MUL_STEPS = 11;
   localparam logic [STEP_W-1:0] STEP_RX_A  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_RX_B  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_RY_A  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_RY_B  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_CY_A  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_CY_B  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_CZ_A  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_CZ_B  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_NX    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_NY    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_FLUSH = 4'd10;

   // Divider: 60 dividend bits, one per cycle.
   localparam int DIV_BITS = 60;
   localparam int CNT_W    = $clog2(DIV_BITS + 2);

   localparam logic signed [39:0] CAM_DIST_Q16   = 40'sd524288;
   localparam logic signed [39:0] CULL_DEPTH_Q16 = -40'sd1310720;
   localparam logic signed [61:0] MARGIN_Q4      = 62'sd160000;
   localparam logic signed [61:0] PIX_MAX        = 62'sd262143;
   localparam logic signed [61:0] PIX_MIN        = -62'sd262144;

   typedef struct packed {
      logic              load;
      logic              mul_en;
      logic [STEP_W-1:0] mul_step;
      logic              div_start;
      logic              div_step;
      logic              div_store;
      logic              div_sel_y;
      logic              commit;
   } polyproj_cmd_type;

   typedef struct packed {
      logic point_ok;
      logic cull;
   } polyproj_sts_type;

   function automatic logic [PIX_W-1:0] sat_pix(input logic signed [61:0] v);
      logic signed [61:0] r;
      if (v > PIX_MAX)      r = PIX_MAX;
      else if (v < PIX_MIN) r = PIX_MIN;
      else                  r = v;
      return r[PIX_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] sat_depth(input logic signed [38:0] v);
      logic signed [38:0] r;
      if (v > 39'sd2147483647)       r = 39'sd2147483647;
      else if (v < -39'sd2147483648) r = -39'sd2147483648;
      else                           r = v;
      return r[COORD_W-1:0];
   endfunction

endpackage

// ===== src/polyproj_ifs.sv =====
// Valid/ready channel interfaces of the projector: request, response and register write.
interface polyproj_req_if import polyproj_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] world_x;
   logic signed [COORD_W-1:0] world_y;
   logic signed [COORD_W-1:0] world_z;
   logic                      point_ok;
   logic                      curve_first;
   modport source (output valid, world_x, world_y, world_z, point_ok, curve_first,
                   input ready);
   modport sink   (input valid, world_x, world_y, world_z, point_ok, curve_first,
                   output ready);
endinterface

interface polyproj_rsp_if import polyproj_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [PIX_W-1:0]   from_x;
   logic signed [PIX_W-1:0]   from_y;
   logic signed [PIX_W-1:0]   to_x;
   logic signed [PIX_W-1:0]   to_y;
   logic signed [COORD_W-1:0] view_depth;
   modport source (output valid, status, from_x, from_y, to_x, to_y, view_depth,
                   input ready);
   modport sink   (input valid, status, from_x, from_y, to_x, to_y, view_depth,
                   output ready);
endinterface

interface polyproj_csr_if import polyproj_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/polyproj_ctrl.sv =====
// Sequencer of the projector: multiply steps, two divisions and result handoff.
module polyproj_ctrl import polyproj_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output polyproj_cmd_type cmd,
   input  polyproj_sts_type sts
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_ROT  = 5'b00010,
      S_DIVX = 5'b00100,
      S_DIVY = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   localparam logic [CNT_W-1:0] CNT_MUL_LAST = CNT_W'(MUL_STEPS - 1);
   localparam logic [CNT_W-1:0] CNT_DIV_LAST = CNT_W'(DIV_BITS + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic             req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.mul_step = cnt_ff[STEP_W-1:0];
      out_valid_in = out_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_ROT;
            end
         end
         S_ROT: begin
            cmd.mul_en = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CNT_MUL_LAST) begin
               cnt_in   = '0;
               state_in = (sts.point_ok && !sts.cull) ? S_DIVX : S_FIN;
            end
         end
         S_DIVX, S_DIVY: begin
            cmd.div_sel_y = (state_ff == S_DIVY);
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               cmd.div_start = 1'b1;
            end else if (cnt_ff == CNT_DIV_LAST) begin
               cmd.div_store = 1'b1;
               cnt_in        = '0;
               state_in      = (state_ff == S_DIVX) ? S_DIVY : S_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_FIN: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_accept_starts_rot: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_ROT)
      else $error("accepted request did not start the multiply sequence");

   a_div_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_start && cmd.div_step) && !(cmd.div_step && cmd.div_store))
      else $error("divider commands overlap");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !cmd.commit)
      else $error("result overwritten while stalled");

endmodule

// ===== src/polyproj_dpath.sv =====
// Projector datapath: registers, shared multiplier, serial divider and result logic.
module polyproj_dpath import polyproj_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DAT_W-1:0]      csr_data,
   input  logic signed [COORD_W-1:0] world_x,
   input  logic signed [COORD_W-1:0] world_y,
   input  logic signed [COORD_W-1:0] world_z,
   input  logic                      point_ok,
   input  logic                      curve_first,
   input  polyproj_cmd_type          cmd,
   output polyproj_sts_type          sts,
   output logic [STATUS_W-1:0]       status,
   output logic [PIX_W-1:0]          from_x,
   output logic [PIX_W-1:0]          from_y,
   output logic [PIX_W-1:0]          to_x,
   output logic [PIX_W-1:0]          to_y,
   output logic [COORD_W-1:0]        view_depth
);

   localparam logic signed [61:0] W8   = 62'(SCREEN_WIDTH * 8);
   localparam logic signed [61:0] H8   = 62'(SCREEN_HEIGHT * 8);
   localparam logic signed [61:0] WMAX = 62'(SCREEN_WIDTH * 16) + MARGIN_Q4;
   localparam logic signed [61:0] HMAX = 62'(SCREEN_HEIGHT * 16) + MARGIN_Q4;

   typedef enum logic [2:0] {OP_HOLD, OP_LOAD, OP_ADD, OP_SUB, OP_RSUB} op_type;
   typedef enum logic [2:0] {
      CAP_NONE, CAP_RX, CAP_RY, CAP_CY, CAP_CZ, CAP_NX, CAP_NY
   } cap_type;

   // Configuration registers.
   logic signed [TRIG_W-1:0]  cos_az_ff, sin_az_ff, cos_el_ff, sin_el_ff;
   logic signed [COORD_W-1:0] pan_x_ff, pan_y_ff, pan_z_ff;
   logic [ZOOM_W-1:0]         zoom_ff;

   // Vertex working registers.
   logic signed [32:0] tx_ff, ty_ff, tz_ff;
   logic               ok_ff, first_ff;
   logic signed [57:0] acc_ff;
   logic signed [35:0] rx_ff, ry_ff;
   logic signed [38:0] cy_ff, cz_ff;
   logic signed [54:0] nx_ff, ny_ff;

   // Divider registers.
   logic [59:0]        dvd_ff;
   logic [40:0]        rem_ff;
   logic               neg_ff;
   logic signed [60:0] qx_ff, qy_ff;

   // Line state.
   logic             pen_ff, pen_in;
   logic [PIX_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;

   // Result registers.
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PIX_W-1:0]    from_x_ff, from_x_in, from_y_ff, from_y_in;
   logic [PIX_W-1:0]    to_x_ff, to_x_in, to_y_ff, to_y_in;
   logic [COORD_W-1:0]  depth_ff, depth_in;

   logic signed [39:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [55:0] prod;
   op_type             op;
   cap_type            cap;
   logic signed [57:0] acc_in, rnd;
   logic signed [39:0] den;
   logic               cull;
   logic signed [59:0] t_val;
   logic [59:0]        t_mag;
   logic [40:0]        dd;
   logic [41:0]        sh, diff;
   logic               ge;
   logic signed [60:0] qpos, quot;
   logic signed [61:0] sx, sy;
   logic               offscr;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_az_ff <= 16'sd14189;
         sin_az_ff <= 16'sd8192;
         cos_el_ff <= 16'sd14849;
         sin_el_ff <= 16'sd6924;
         pan_x_ff  <= '0;
         pan_y_ff  <= '0;
         pan_z_ff  <= '0;
         zoom_ff   <= 15'd960;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COS_AZ: cos_az_ff <= csr_data[TRIG_W-1:0];
            CSR_SIN_AZ: sin_az_ff <= csr_data[TRIG_W-1:0];
            CSR_COS_EL: cos_el_ff <= csr_data[TRIG_W-1:0];
            CSR_SIN_EL: sin_el_ff <= csr_data[TRIG_W-1:0];
            CSR_PAN_X:  pan_x_ff  <= csr_data;
            CSR_PAN_Y:  pan_y_ff  <= csr_data;
            CSR_PAN_Z:  pan_z_ff  <= csr_data;
            CSR_ZOOM:   zoom_ff   <= csr_data[ZOOM_W-1:0];
            default: ;
         endcase
      end
   end

   // Operand selection per multiply step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      op    = OP_HOLD;
      cap   = CAP_NONE;
      unique case (cmd.mul_step)
         STEP_RX_A:  begin mul_a = 40'(tx_ff); mul_b = cos_az_ff; op = OP_LOAD; end
         STEP_RX_B:  begin mul_a = 40'(ty_ff); mul_b = sin_az_ff; op = OP_ADD; end
         STEP_RY_A:  begin
            mul_a = 40'(ty_ff); mul_b = cos_az_ff; op = OP_LOAD; cap = CAP_RX;
         end
         STEP_RY_B:  begin mul_a = 40'(tx_ff); mul_b = sin_az_ff; op = OP_SUB; end
         STEP_CY_A:  begin
            mul_a = 40'(tz_ff); mul_b = sin_el_ff; op = OP_LOAD; cap = CAP_RY;
         end
         STEP_CY_B:  begin mul_a = 40'(ry_ff); mul_b = cos_el_ff; op = OP_RSUB; end
         STEP_CZ_A:  begin
            mul_a = 40'(ry_ff); mul_b = sin_el_ff; op = OP_LOAD; cap = CAP_CY;
         end
         STEP_CZ_B:  begin mul_a = 40'(tz_ff); mul_b = cos_el_ff; op = OP_ADD; end
         STEP_NX:    begin
            mul_a = 40'(rx_ff); mul_b = $signed({1'b0, zoom_ff}); op = OP_LOAD;
            cap = CAP_CZ;
         end
         STEP_NY:    begin
            mul_a = 40'(cy_ff); mul_b = $signed({1'b0, zoom_ff}); op = OP_LOAD;
            cap = CAP_NX;
         end
         STEP_FLUSH: cap = CAP_NY;
         default: ;
      endcase
   end

   assign prod = mul_a * mul_b;
   assign rnd  = (acc_ff + 58'sd8192) >>> 14;

   always_comb begin
      unique case (op)
         OP_LOAD: acc_in = 58'(prod);
         OP_ADD:  acc_in = acc_ff + 58'(prod);
         OP_SUB:  acc_in = acc_ff - 58'(prod);
         OP_RSUB: acc_in = 58'(prod) - acc_ff;
         default: acc_in = acc_ff;
      endcase
   end

   assign den  = 40'(cz_ff) + CAM_DIST_Q16;
   assign cull = (40'(cz_ff) < CULL_DEPTH_Q16) || (den <= 40'sd0);
   assign sts.point_ok = ok_ff;
   assign sts.cull     = cull;

   // Rounded division: quotient = floor((16*n + den) / (2*den)).
   assign t_val = ((cmd.div_sel_y ? 60'(ny_ff) : 60'(nx_ff)) <<< 4) + 60'(den);
   assign t_mag = t_val[59] ? (~t_val + 60'd1) : t_val;
   assign dd    = {den[39:0], 1'b0};
   assign sh    = {rem_ff, dvd_ff[59]};
   assign diff  = sh - {1'b0, dd};
   assign ge    = (sh >= {1'b0, dd});
   assign qpos  = $signed({1'b0, dvd_ff});
   assign quot  = neg_ff ? -(qpos + 61'(rem_ff != '0)) : qpos;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tx_ff    <= 33'(world_x) - 33'(pan_x_ff);
         ty_ff    <= 33'(world_y) - 33'(pan_y_ff);
         tz_ff    <= 33'(world_z) - 33'(pan_z_ff);
         ok_ff    <= point_ok;
         first_ff <= curve_first;
      end
      if (cmd.mul_en) begin
         acc_ff <= acc_in;
         unique case (cap)
            CAP_RX:  rx_ff <= rnd[35:0];
            CAP_RY:  ry_ff <= rnd[35:0];
            CAP_CY:  cy_ff <= rnd[38:0];
            CAP_CZ:  cz_ff <= rnd[38:0];
            CAP_NX:  nx_ff <= acc_ff[54:0];
            CAP_NY:  ny_ff <= acc_ff[54:0];
            default: ;
         endcase
      end
      if (cmd.div_start) begin
         dvd_ff <= t_mag;
         rem_ff <= '0;
         neg_ff <= t_val[59];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? diff[40:0] : sh[40:0];
         dvd_ff <= {dvd_ff[58:0], ge};
      end
      if (cmd.div_store) begin
         if (cmd.div_sel_y) qy_ff <= quot;
         else               qx_ff <= quot;
      end
   end

   assign sx     = W8 + 62'(qx_ff);
   assign sy     = H8 - 62'(qy_ff);
   assign offscr = (sx < -MARGIN_Q4) || (sx > WMAX) || (sy < -MARGIN_Q4) || (sy > HMAX);

   always_comb begin
      pen_in    = pen_ff && !first_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      status_in = ST_INVALID;
      from_x_in = '0;
      from_y_in = '0;
      to_x_in   = '0;
      to_y_in   = '0;
      depth_in  = '0;
      if (!ok_ff) begin
         pen_in = 1'b0;
      end else if (cull) begin
         status_in = ST_CULLED;
         pen_in    = 1'b0;
         depth_in  = sat_depth(cz_ff);
      end else begin
         depth_in  = sat_depth(cz_ff);
         to_x_in   = sat_pix(sx);
         to_y_in   = sat_pix(sy);
         prev_x_in = to_x_in;
         prev_y_in = to_y_in;
         if (offscr) begin
            status_in = ST_OFFSCR;
            pen_in    = 1'b0;
         end else if (pen_in) begin
            status_in = ST_SEGMENT;
            from_x_in = prev_x_ff;
            from_y_in = prev_y_ff;
         end else begin
            status_in = ST_START;
            pen_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff    <= 1'b0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else if (cmd.commit) begin
         pen_ff    <= pen_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         from_x_ff <= from_x_in;
         from_y_ff <= from_y_in;
         to_x_ff   <= to_x_in;
         to_y_ff   <= to_y_in;
         depth_ff  <= depth_in;
      end
   end

   assign status     = status_ff;
   assign from_x     = from_x_ff;
   assign from_y     = from_y_ff;
   assign to_x       = to_x_ff;
   assign to_y       = to_y_ff;
   assign view_depth = depth_ff;

endmodule

// ===== src/polyline_perspective_projector.sv =====
// Top level of the polyline perspective projector: channels, controller and datapath.
// Each request on req_chan carries one 3-D polyline vertex in Q16.16 world units plus
// its point_ok and curve_first flags. Every request yields exactly one response on
// rsp_chan with a status code, the projected Q14.4 screen point, the previous point
// when a segment is drawn, and the camera depth.
// Configuration registers are written on csr_chan, which is always ready; write them
// only while no request is in flight. Indexes beyond the register list are ignored.
// A request runs the multiply sequence on the shared multiplier (azimuth and elevation
// rotation and zoom products), then two passes of the one-bit-per-cycle divider for
// the x and y perspective quotients, then a commit step that loads the response register.
// Invalid or depth-culled vertices skip the divider. A new request is accepted once
// the previous one has committed.
// The response sits in an output register, so a stalled receiver only holds the
// next request in its commit step until the register frees up.
// Reset is synchronous and active high; it restores the register defaults, lifts
// the pen and clears the previous screen point to zero.
module polyline_perspective_projector import polyproj_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input logic            clock,
   input logic            reset,
   polyproj_req_if.sink   req_chan,
   polyproj_rsp_if.source rsp_chan,
   polyproj_csr_if.sink   csr_chan
);

   polyproj_cmd_type cmd;
   polyproj_sts_type sts;

   // The register port never stalls; writes land in the datapath directly.
   assign csr_chan.ready = 1'b1;

   polyproj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   polyproj_dpath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_chan.valid),
      .csr_index   (csr_chan.index),
      .csr_data    (csr_chan.data),
      .world_x     (req_chan.world_x),
      .world_y     (req_chan.world_y),
      .world_z     (req_chan.world_z),
      .point_ok    (req_chan.point_ok),
      .curve_first (req_chan.curve_first),
      .cmd         (cmd),
      .sts         (sts),
      .status      (rsp_chan.status),
      .from_x      (rsp_chan.from_x),
      .from_y      (rsp_chan.from_y),
      .to_x        (rsp_chan.to_x),
      .to_y        (rsp_chan.to_y),
      .view_depth  (rsp_chan.view_depth)
   );

endmodule
